FILE: rtl/usos_pkg.sv
// Shared types and constants for the rear ultrasonic obstacle scanner.
// Used by usos_cfg, usos_core and the top level; depends on nothing else.
`default_nettype none

package usos_pkg;

    localparam int LINES     = 3;   // sensors with physical trigger/echo lines
    localparam int TICK_W    = 16;  // phase and width counters
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int HIT_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_PULSE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_CM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_CM  = 3'd5;

    localparam logic [TICK_W-1:0] WIDTH_MAX = 16'hFFFF;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_TRIGGER = 5'b00010,
        PH_WAIT    = 5'b00100,
        PH_RESET   = 5'b01000,
        PH_GAP     = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0]  trigger_ticks;
        logic [15:0] echo_timeout_ticks;
        logic [9:0]  reset_pulse_ticks;
        logic [15:0] gap_ticks;
        logic [15:0] limit;          // critical_cm * ticks_per_cm
    } cfg_t;

    typedef struct packed {
        logic [LINES-1:0]  trigger_lines;
        logic [LINES-1:0]  echo_drive;
        logic              busy_res;
        logic              done_res;
        logic              obstacle;
        logic [HIT_W-1:0]  hit_sensor;
        logic [TICK_W-1:0] echo_width;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/usos_cfg.sv
// Configuration register file for the scanner, with the derived
// obstacle width limit. Depends on usos_pkg.
`default_nettype none

module usos_cfg (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_we,
    input  wire [usos_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [usos_pkg::CFG_DAT_W-1:0]  cfg_data,
    output usos_pkg::cfg_t                 cfg
);
    import usos_pkg::*;

    logic [7:0]  trigger_reg;
    logic [15:0] timeout_reg;
    logic [9:0]  reset_pulse_reg;
    logic [15:0] gap_reg;
    logic [7:0]  critical_reg;
    logic [7:0]  per_cm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_reg     <= 8'd10;
            timeout_reg     <= 16'd30000;
            reset_pulse_reg <= 10'd200;
            gap_reg         <= 16'd5000;
            critical_reg    <= 8'd18;
            per_cm_reg      <= 8'd58;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TRIGGER_TICKS: trigger_reg     <= cfg_data[7:0];
                REG_ECHO_TIMEOUT:  timeout_reg     <= cfg_data;
                REG_RESET_PULSE:   reset_pulse_reg <= cfg_data[9:0];
                REG_GAP_TICKS:     gap_reg         <= cfg_data;
                REG_CRITICAL_CM:   critical_reg    <= cfg_data[7:0];
                REG_TICKS_PER_CM:  per_cm_reg      <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // 8 x 8 product, at most 65025, so it fits the width counter
    assign cfg.trigger_ticks      = trigger_reg;
    assign cfg.echo_timeout_ticks = timeout_reg;
    assign cfg.reset_pulse_ticks  = reset_pulse_reg;
    assign cfg.gap_ticks          = gap_reg;
    assign cfg.limit              = 16'(critical_reg) * 16'(per_cm_reg);

endmodule

`default_nettype wire

FILE: rtl/usos_core.sv
// Scan sequencer: per-tick phase update, echo edge detection and width count.
// Produces the next result for each tick. Depends on usos_pkg.
`default_nettype none

module usos_core #(
    parameter int NUM_SENSORS = 3
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         step,
    input  wire                         start_req,
    input  wire [usos_pkg::LINES-1:0]   echo_levels,
    input  usos_pkg::cfg_t              cfg,
    output usos_pkg::res_t              res
);
    import usos_pkg::*;

    localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SENSORS - 1);

    phase_t             phase_reg,  phase_next;
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    logic [TICK_W-1:0]  ticks_reg,  ticks_next;
    logic [TICK_W-1:0]  width_reg,  width_next;
    logic [LINES-1:0]   prev_reg;
    logic               first_reg,  first_next;
    logic [2:0]         flags_reg,  flags_next;
    logic               done_now;
    logic               change;
    logic [TICK_W-1:0]  ticks_inc;
    logic [IDX_W:0]     idx_inc;

    function automatic logic [LINES-1:0] line_mask(input logic [IDX_W-1:0] idx);
        logic [LINES-1:0] m;
        for (int k = 0; k < LINES; k++)
        begin
            m[k] = (int'(idx) == k);
        end
        return m;
    endfunction

    assign change    = |((echo_levels ^ prev_reg) & line_mask(idx_reg));
    assign ticks_inc = ticks_reg + 1'b1;
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        ticks_next = ticks_reg;
        width_next = width_reg;
        first_next = first_reg;
        flags_next = flags_reg;
        done_now   = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    flags_next = '0;
                    idx_next   = '0;
                    phase_next = PH_TRIGGER;
                    ticks_next = '0;
                    width_next = '0;
                    first_next = 1'b0;
                end
            end
            PH_TRIGGER:
            begin
                ticks_next = ticks_inc;
                if (ticks_inc >= TICK_W'(cfg.trigger_ticks))
                begin
                    phase_next = PH_WAIT;
                    ticks_next = '0;
                end
            end
            PH_WAIT:
            begin
                ticks_next = ticks_inc;
                if (first_reg && width_reg != WIDTH_MAX)
                begin
                    width_next = width_reg + 1'b1;
                end
                if (change && first_reg)
                begin
                    // Second edge: measurement complete, timeout does not apply
                    if (width_next < cfg.limit)
                    begin
                        phase_next = PH_IDLE;
                        ticks_next = '0;
                        flags_next = {idx_inc[HIT_W-1:0], 1'b1};
                        done_now   = 1'b1;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        phase_next = PH_IDLE;
                        ticks_next = '0;
                        flags_next = '0;
                        done_now   = 1'b1;
                    end
                    else if (cfg.gap_ticks == '0)
                    begin
                        idx_next   = idx_inc[IDX_W-1:0];
                        phase_next = PH_TRIGGER;
                        ticks_next = '0;
                        width_next = '0;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_GAP;
                        ticks_next = '0;
                    end
                end
                else
                begin
                    if (change)
                    begin
                        first_next = 1'b1;
                        width_next = '0;
                    end
                    if (ticks_inc >= cfg.echo_timeout_ticks)
                    begin
                        phase_next = PH_RESET;
                        ticks_next = '0;
                    end
                end
            end
            PH_RESET:
            begin
                ticks_next = ticks_inc;
                if (ticks_inc >= TICK_W'(cfg.reset_pulse_ticks))
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        phase_next = PH_IDLE;
                        ticks_next = '0;
                        flags_next = '0;
                        done_now   = 1'b1;
                    end
                    else if (cfg.gap_ticks == '0)
                    begin
                        idx_next   = idx_inc[IDX_W-1:0];
                        phase_next = PH_TRIGGER;
                        ticks_next = '0;
                        width_next = '0;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_GAP;
                        ticks_next = '0;
                    end
                end
            end
            PH_GAP:
            begin
                ticks_next = ticks_inc;
                if (ticks_inc >= cfg.gap_ticks)
                begin
                    idx_next   = idx_inc[IDX_W-1:0];
                    phase_next = PH_TRIGGER;
                    ticks_next = '0;
                    width_next = '0;
                    first_next = 1'b0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                ticks_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            idx_reg   <= '0;
            ticks_reg <= '0;
            width_reg <= '0;
            prev_reg  <= '0;
            first_reg <= 1'b0;
            flags_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            ticks_reg <= ticks_next;
            width_reg <= width_next;
            prev_reg  <= echo_levels;
            first_reg <= first_next;
            flags_reg <= flags_next;
        end
    end

    assign res.trigger_lines = (phase_next == PH_TRIGGER) ? line_mask(idx_next) : '0;
    assign res.echo_drive    = (phase_next == PH_RESET) ? line_mask(idx_next) : '0;
    assign res.busy_res      = (phase_next != PH_IDLE);
    assign res.done_res      = done_now;
    assign res.obstacle      = flags_next[0];
    assign res.hit_sensor    = flags_next[2:1];
    assign res.echo_width    = width_next;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.done_res |-> !res.busy_res)
        else $error("scan done reported while still busy");

    a_trig_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !((|res.trigger_lines) && (|res.echo_drive)))
        else $error("trigger and echo drive active together");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_IDLE && !start_req) |=> phase_reg == PH_IDLE)
        else $error("left idle without a start request");

    a_obstacle_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.obstacle && !flags_reg[0]) |-> res.done_res)
        else $error("obstacle flag set outside scan completion");
`endif

endmodule

`default_nettype wire

FILE: rtl/rear_ultrasonic_obstacle_scanner.sv
// Rear ultrasonic obstacle scanner, one transaction per microsecond tick.
// Accepted ticks pass the input register, then the result register; the output can stall.
// One tick per cycle unless out_ready stalls; the whole phase update fits between those two.
// Reset (rst_n low, asynchronous): scan idle, counters and result flags cleared,
// configuration registers back to their defaults.
`default_nettype none

module rear_ultrasonic_obstacle_scanner #(
    parameter int NUM_SENSORS = 3
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_we,
    input  wire [usos_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [usos_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire                            start_req,
    input  wire [usos_pkg::LINES-1:0]      echo_levels,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [usos_pkg::LINES-1:0]     trigger_lines,
    output logic [usos_pkg::LINES-1:0]     echo_drive,
    output logic                           busy_res,
    output logic                           done_res,
    output logic                           obstacle,
    output logic [usos_pkg::HIT_W-1:0]     hit_sensor,
    output logic [usos_pkg::TICK_W-1:0]    echo_width
);
    import usos_pkg::*;

    cfg_t             cfg;
    res_t             res_comb;
    res_t             res_reg;
    logic             s1_valid_reg;
    logic             s1_start_reg;
    logic [LINES-1:0] s1_echo_reg;
    logic             out_valid_reg;
    logic             step;

    // Advance the held tick when the result register is free or being emptied
    assign step     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_start_reg <= start_req;
            s1_echo_reg  <= echo_levels;
        end
        if (step)
        begin
            res_reg <= res_comb;
        end
    end

    usos_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    usos_core #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .start_req   (s1_start_reg),
        .echo_levels (s1_echo_reg),
        .cfg         (cfg),
        .res         (res_comb)
    );

    assign out_valid     = out_valid_reg;
    assign trigger_lines = res_reg.trigger_lines;
    assign echo_drive    = res_reg.echo_drive;
    assign busy_res      = res_reg.busy_res;
    assign done_res      = res_reg.done_res;
    assign obstacle      = res_reg.obstacle;
    assign hit_sensor    = res_reg.hit_sensor;
    assign echo_width    = res_reg.echo_width;

`ifndef SYNTHESIS
    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed tick produced no result");

    a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !step)
        else $error("result overwritten while stalled");

    a_held_tick_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !step) |=> s1_valid_reg)
        else $error("held tick dropped without processing");
`endif

endmodule

`default_nettype wire

FILE: dv/scan_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the rear ultrasonic obstacle scanner. It mirrors the register
// writes, predicts one reading per accepted tick and checks every delivered reading.
// Depends on usos_pkg for the phase encoding, register indexes and reading layout.
module scan_checker #(
    parameter int NUM_SENSORS = 3
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_we,
    input  wire [usos_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [usos_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  wire                            in_valid,
    input  wire                            in_ready,
    input  wire                            start_req,
    input  wire [usos_pkg::LINES-1:0]      echo_levels,
    input  wire                            out_valid,
    input  wire                            out_ready,
    input  wire [usos_pkg::LINES-1:0]      trigger_lines,
    input  wire [usos_pkg::LINES-1:0]      echo_drive,
    input  wire                            busy_res,
    input  wire                            done_res,
    input  wire                            obstacle,
    input  wire [usos_pkg::HIT_W-1:0]      hit_sensor,
    input  wire [usos_pkg::TICK_W-1:0]     echo_width,
    output int                             mismatches,
    output int                             readings_pending,
    output int                             readings_checked,
    output int                             scans_finished,
    output int                             obstacles_reported,
    output logic                           scan_active
);
    import usos_pkg::*;

    // register copies
    logic [7:0]  trig_len;
    logic [15:0] echo_tmo;
    logic [9:0]  pulse_len;
    logic [15:0] gap_len;
    logic [7:0]  crit_cm;
    logic [7:0]  cm_ticks;

    // scan state
    phase_t      ph;
    logic [1:0]  sensor;
    logic [15:0] ph_ticks;
    logic [15:0] width_cnt;
    logic [2:0]  prev_echo;
    logic        edge_armed;
    logic [2:0]  flags;
    logic        done_flag;

    res_t expected_readings[$];

    function automatic logic [LINES-1:0] line_of(input logic [1:0] idx);
        line_of = '0;
        if (int'(idx) < LINES)
            line_of[idx] = 1'b1;
    endfunction

    task automatic begin_sensor(input logic [1:0] idx);
        sensor     = idx;
        ph         = PH_TRIGGER;
        ph_ticks   = '0;
        width_cnt  = '0;
        edge_armed = 1'b0;
    endtask

    task automatic finish_scan(input logic [2:0] result);
        ph        = PH_IDLE;
        ph_ticks  = '0;
        flags     = result;
        done_flag = 1'b1;
    endtask

    task automatic next_sensor();
        if (int'(sensor) + 1 >= NUM_SENSORS)
            finish_scan(3'b000);
        else if (gap_len == 16'd0)
            begin_sensor(sensor + 2'd1);
        else
        begin
            ph       = PH_GAP;
            ph_ticks = '0;
        end
    endtask

    // Advance the scan by one tick and queue the reading it produces.
    task automatic scan_tick(input logic go, input logic [LINES-1:0] echo);
        logic [LINES-1:0] change;
        res_t             r;
        change    = (echo ^ prev_echo) & line_of(sensor);
        done_flag = 1'b0;
        case (ph)
            PH_IDLE:
                if (go)
                begin
                    flags = '0;
                    begin_sensor(2'd0);
                end
            PH_TRIGGER:
            begin
                ph_ticks = ph_ticks + 16'd1;
                if (ph_ticks >= 16'(trig_len))
                begin
                    ph       = PH_WAIT;
                    ph_ticks = '0;
                end
            end
            PH_WAIT:
            begin
                ph_ticks = ph_ticks + 16'd1;
                if (edge_armed && width_cnt != WIDTH_MAX)
                    width_cnt = width_cnt + 16'd1;
                // a closing edge wins over the timeout on the same tick
                if (change != '0 && edge_armed)
                begin
                    if (32'(width_cnt) < 32'(crit_cm) * 32'(cm_ticks))
                        finish_scan({sensor + 2'd1, 1'b1});
                    else
                        next_sensor();
                end
                else
                begin
                    if (change != '0)
                    begin
                        edge_armed = 1'b1;
                        width_cnt  = '0;
                    end
                    if (ph_ticks >= echo_tmo)
                    begin
                        ph       = PH_RESET;
                        ph_ticks = '0;
                    end
                end
            end
            PH_RESET:
            begin
                ph_ticks = ph_ticks + 16'd1;
                if (ph_ticks >= 16'(pulse_len))
                    next_sensor();
            end
            PH_GAP:
            begin
                ph_ticks = ph_ticks + 16'd1;
                if (ph_ticks >= gap_len)
                    begin_sensor(sensor + 2'd1);
            end
            default:
            begin
                ph       = PH_IDLE;
                ph_ticks = '0;
            end
        endcase
        prev_echo = echo;

        r.trigger_lines = (ph == PH_TRIGGER) ? line_of(sensor) : '0;
        r.echo_drive    = (ph == PH_RESET) ? line_of(sensor) : '0;
        r.busy_res      = (ph != PH_IDLE);
        r.done_res      = done_flag;
        r.obstacle      = flags[0];
        r.hit_sensor    = flags[2:1];
        r.echo_width    = width_cnt;
        expected_readings.push_back(r);

        if (done_flag)
        begin
            scans_finished++;
            if (flags[0])
                obstacles_reported++;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            trig_len   = 8'd10;
            echo_tmo   = 16'd30000;
            pulse_len  = 10'd200;
            gap_len    = 16'd5000;
            crit_cm    = 8'd18;
            cm_ticks   = 8'd58;
            ph         = PH_IDLE;
            sensor     = '0;
            ph_ticks   = '0;
            width_cnt  = '0;
            prev_echo  = '0;
            edge_armed = 1'b0;
            flags      = '0;
            done_flag  = 1'b0;
            expected_readings.delete();
            mismatches         = 0;
            readings_checked   = 0;
            scans_finished     = 0;
            obstacles_reported = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TRIGGER_TICKS: trig_len  = cfg_data[7:0];
                    REG_ECHO_TIMEOUT:  echo_tmo  = cfg_data;
                    REG_RESET_PULSE:   pulse_len = cfg_data[9:0];
                    REG_GAP_TICKS:     gap_len   = cfg_data;
                    REG_CRITICAL_CM:   crit_cm   = cfg_data[7:0];
                    REG_TICKS_PER_CM:  cm_ticks  = cfg_data[7:0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $error("reading delivered with none expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    readings_checked++;
                    check_field("trigger_lines", 16'(want.trigger_lines), 16'(trigger_lines));
                    check_field("echo_drive", 16'(want.echo_drive), 16'(echo_drive));
                    check_field("busy_res", 16'(want.busy_res), 16'(busy_res));
                    check_field("done_res", 16'(want.done_res), 16'(done_res));
                    check_field("obstacle", 16'(want.obstacle), 16'(obstacle));
                    check_field("hit_sensor", 16'(want.hit_sensor), 16'(hit_sensor));
                    check_field("echo_width", want.echo_width, echo_width);
                end
            end

            if (in_valid && in_ready)
                scan_tick(start_req, echo_levels);
        end
        readings_pending = expected_readings.size();
        scan_active      = (ph != PH_IDLE);
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the scanner testbench: clock, reset, register setup, tick and reading
// handshakes, and the verdict. Depends on usos_pkg, the scanner RTL and scan_checker.
module testbench;
    import usos_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 start_req;
    logic [LINES-1:0]     echo_levels;
    logic                 out_valid;
    logic                 out_ready;
    logic [LINES-1:0]     trigger_lines;
    logic [LINES-1:0]     echo_drive;
    logic                 busy_res;
    logic                 done_res;
    logic                 obstacle;
    logic [HIT_W-1:0]     hit_sensor;
    logic [TICK_W-1:0]    echo_width;

    int   mismatches;
    int   readings_pending;
    int   readings_checked;
    int   scans_finished;
    int   obstacles_reported;
    logic scan_active;

    int               send_idle_pct = 16;
    int               recv_idle_pct = 49;
    bit               stall_once    = 1'b0;
    bit               stall_taken   = 1'b0;
    int               stall_left    = 0;
    logic [LINES-1:0] echo_now      = '0;

    rear_ultrasonic_obstacle_scanner #(.NUM_SENSORS(3)) uut (.*);

    scan_checker #(.NUM_SENSORS(3)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // reading side: random stalls, plus one long hold-off when asked
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_once && !stall_taken)
            begin
                stall_taken = 1'b1;
                stall_left  = 300;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic send_tick(input logic go, input logic [LINES-1:0] echo);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        start_req   <= go;
        echo_levels <= echo;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Toggle every echo line until the scan ends, then drain all readings.
    task automatic quiesce();
        while (scan_active)
        begin
            echo_now = ~echo_now;
            send_tick(1'b0, echo_now);
        end
        in_valid <= 1'b0;
        while (readings_pending != 0)
            @(negedge clk);
    endtask

    task automatic load_scan_config(input logic [7:0] trig, input logic [15:0] tmo,
                                    input logic [9:0] pulse, input logic [15:0] gap,
                                    input logic [7:0] crit, input logic [7:0] per_cm);
        logic [CFG_DAT_W-1:0] value [6];
        logic [CFG_IDX_W-1:0] reg_idx [6];
        value   = '{16'(trig), tmo, 16'(pulse), gap, 16'(crit), 16'(per_cm)};
        reg_idx = '{REG_TRIGGER_TICKS, REG_ECHO_TIMEOUT, REG_RESET_PULSE,
                    REG_GAP_TICKS, REG_CRITICAL_CM, REG_TICKS_PER_CM};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_idx[i];
            cfg_data  <= value[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Echo lines flip at per-line rates that change every 64 ticks, so echo
    // widths spread across hits, far echoes and timeouts.
    task automatic random_ticks(input int count, input int rate_cap);
        int rate [LINES];
        for (int n = 0; n < count; n++)
        begin
            if (n % 64 == 0)
                foreach (rate[k])
                    rate[k] = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, rate_cap);
            for (int k = 0; k < LINES; k++)
                if ($urandom_range(0, 255) < rate[k])
                    echo_now[k] = ~echo_now[k];
            send_tick($urandom_range(0, 9) == 0, echo_now);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        start_req   = 1'b0;
        echo_levels = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: a short echo on sensor 1 is a hit. Edges during the
        // trigger and on other sensors' lines are ignored, as is a second start.
        send_tick(1'b1, echo_now);
        for (int i = 0; i < 13; i++)
        begin
            if (i == 3 || i == 10 || i == 12)
                echo_now[0] = ~echo_now[0];
            if (i == 6)
                echo_now[1] = 1'b1;
            send_tick(i == 5, echo_now);
        end
        quiesce();

        // Zero trigger/reset act as one tick, zero gap skips; zero scale never hits.
        load_scan_config(8'd0, 16'd2, 10'd0, 16'd0, 8'd0, 8'd0);
        echo_now = '0;
        send_tick(1'b1, echo_now);
        // the closing edge comes together with the timeout, and the edge wins
        repeat (3)
        begin
            echo_now = ~echo_now;
            send_tick(1'b0, echo_now);
        end
        quiesce();
        // steady echo: sensor 1 times out and gets its reset pulse
        repeat (5) send_tick(1'b1, echo_now);
        quiesce();

        for (int m = 0; m < 3; m++)
        begin
            send_idle_pct = (m == 0) ? 16 : (m == 1) ? 49 : 0;
            recv_idle_pct = (m == 0) ? 49 : (m == 1) ? 16 : 0;
            stall_once    = (m == 2);
            load_scan_config(8'($urandom_range(1, 6)), 16'($urandom_range(8, 60)),
                             10'($urandom_range(1, 8)), 16'($urandom_range(0, 10)),
                             8'($urandom_range(1, 6)), 8'($urandom_range(1, 10)));
            random_ticks(300, 96);
            quiesce();
            if (m == 1)
            begin
                // every register at its upper end
                load_scan_config(8'd255, 16'hFFFF, 10'd1023, 16'hFFFF, 8'd255, 8'd255);
                random_ticks(250, 160);
                quiesce();
            end
        end

        repeat (4) @(posedge clk);
        $display("checked %0d ticks over %0d finished scans, %0d of them with an obstacle",
                 readings_checked, scans_finished, obstacles_reported);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
